/* src/cbts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// CAN bit-timing solver package
// Shared types, constants and the sample-point split function.
// ----------------------------------------------------------------------------
package cbts_pkg;

    localparam int CLK_W   = 28;
    localparam int RATE_W  = 20;
    localparam int QUOT_W  = 15;
    localparam int SUM_W   = 5;
    localparam int CNT_W   = 5;
    localparam int PRESC_W = 11;

    localparam logic [RATE_W-1:0]  FAST_RATE     = 20'd1000000;
    localparam logic [SUM_W-1:0]   QUANTA_FAST   = 5'd10;
    localparam logic [SUM_W-1:0]   QUANTA_SLOW   = 5'd18;
    localparam logic [SUM_W-1:0]   MIN_SUM       = 5'd2;
    localparam logic [QUOT_W-1:0]  PRESCALER_MAX = 15'd1024;
    localparam logic [SUM_W-1:0]   MAX_SEG1      = 5'd16;
    localparam logic [SUM_W-1:0]   MAX_SEG2      = 5'd8;
    localparam logic [1:0]         SJW_CODE      = 2'd3;
    localparam logic [14:0]        PERMILL_FULL  = 15'd1000;
    localparam logic [14:0]        PERMILL_LIMIT = 15'd901;
    localparam logic [CLK_W-1:0]   CLOCK_RESET   = 28'd54000000;

    localparam logic [CNT_W-1:0]   DIV_STEPS     = 5'd28;
    localparam logic [CNT_W-1:0]   TRIAL_STEPS   = 5'd15;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_TRIAL = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    // Splits the segment sum for a sample point near 87.5 percent. The rounded
    // split is kept unless its sample point lies above 90 percent.
    function automatic logic [SUM_W-1:0] seg1_split(input logic [SUM_W-1:0] sum);
        logic [7:0]       t_round;
        logic [7:0]       t_trunc;
        logic [SUM_W-1:0] s_round;
        logic [14:0]      lhs;
        logic [14:0]      rhs;
        t_round = ({3'b000, sum} * 8'd7) + 8'd3;
        t_trunc = ({3'b000, sum} * 8'd7) - 8'd1;
        s_round = t_round[7:3];
        lhs = PERMILL_FULL * ({10'd0, s_round} + 15'd1);
        rhs = PERMILL_LIMIT * ({10'd0, sum} + 15'd1);
        if (lhs >= rhs)
        begin
            return t_trunc[7:3];
        end
        return s_round;
    endfunction

endpackage
`default_nettype wire

/* src/can_bit_timing_solver_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// CAN bit-timing solver core
// Finds prescaler and segment codes for a requested bitrate from the
// configured peripheral clock, using one shared shift-subtract divider.
// ----------------------------------------------------------------------------
// Flow: after acceptance, the 28-step clock division runs, then one 15-step
// modulo trial per divisor (one to sixteen trials), a check and the result;
// a zero bitrate skips the division and an out-of-range quotient skips the trials.
// Throughput: one transaction at a time; the clock division and the modulo
// trials share the same divider.
// Reset: asynchronous, active low; the clock register returns to 54000000.
module can_bit_timing_solver_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cbts_pkg::CLK_W-1:0]      cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [cbts_pkg::RATE_W-1:0]     req_bitrate,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 ok,
    output logic [cbts_pkg::PRESC_W-1:0]         prescaler,
    output logic [1:0]                           jump_width_code,
    output logic [3:0]                           seg1_code,
    output logic [2:0]                           seg2_code
);
    import cbts_pkg::*;

    state_t                 state_reg, state_next;
    logic [CLK_W-1:0]       clock_reg;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [RATE_W-1:0]      rem_reg, rem_next;
    logic [CLK_W-1:0]       quo_reg, quo_next;
    logic [RATE_W-1:0]      div_reg, div_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [QUOT_W-1:0]      quot_reg, quot_next;
    logic [RATE_W-1:0]      rem1_reg, rem1_next;
    logic                   res_ok_reg, res_ok_next;
    logic [PRESC_W-1:0]     res_presc_reg, res_presc_next;
    logic [3:0]             res_seg1_reg, res_seg1_next;
    logic [2:0]             res_seg2_reg, res_seg2_next;
    logic                   out_valid_reg;
    logic                   ok_reg;
    logic [PRESC_W-1:0]     presc_reg;
    logic [1:0]             sjw_reg;
    logic [3:0]             seg1_reg;
    logic [2:0]             seg2_reg;

    logic [RATE_W:0]        trial;
    logic                   trial_ge;
    logic [RATE_W-1:0]      step_rem;
    logic [CLK_W-1:0]       step_quo;
    logic [QUOT_W-1:0]      presc_cand;
    logic [SUM_W-1:0]       seg1_val;
    logic [SUM_W-1:0]       seg2_val;
    logic                   sol_ok;
    logic                   out_load;
    logic                   in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;

    // Shared restoring divider step.
    assign trial    = {rem_reg, quo_reg[CLK_W-1]};
    assign trial_ge = (trial >= {1'b0, div_reg});
    assign step_rem = trial_ge ? (trial[RATE_W-1:0] - div_reg) : trial[RATE_W-1:0];
    assign step_quo = {quo_reg[CLK_W-2:0], trial_ge};

    assign presc_cand = quo_reg[QUOT_W-1:0];
    assign seg1_val   = seg1_split(sum_reg);
    assign seg2_val   = sum_reg - seg1_val;
    assign sol_ok     = (presc_cand != '0) && (presc_cand <= PRESCALER_MAX)
                        && (rem1_reg < {{(RATE_W-QUOT_W){1'b0}}, quot_reg})
                        && (seg1_val != '0) && (seg1_val <= MAX_SEG1)
                        && (seg2_val != '0) && (seg2_val <= MAX_SEG2);

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        sum_next       = sum_reg;
        quot_next      = quot_reg;
        rem1_next      = rem1_reg;
        res_ok_next    = res_ok_reg;
        res_presc_next = res_presc_reg;
        res_seg1_next  = res_seg1_reg;
        res_seg2_next  = res_seg2_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_ok_next    = 1'b0;
                    res_presc_next = '0;
                    res_seg1_next  = '0;
                    res_seg2_next  = '0;
                    rem_next       = '0;
                    quo_next       = clock_reg;
                    div_next       = req_bitrate;
                    sum_next       = (req_bitrate >= FAST_RATE) ? (QUANTA_FAST - 5'd1)
                                                                : (QUANTA_SLOW - 5'd1);
                    if (req_bitrate == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cnt_next   = DIV_STEPS;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (cnt_reg != '0)
                begin
                    rem_next = step_rem;
                    quo_next = step_quo;
                    cnt_next = cnt_reg - 5'd1;
                end
                else if ((quo_reg == '0) || (quo_reg[CLK_W-1:QUOT_W] != '0))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    quot_next  = quo_reg[QUOT_W-1:0];
                    rem1_next  = rem_reg;
                    rem_next   = '0;
                    quo_next   = {quo_reg[QUOT_W-1:0], {(CLK_W-QUOT_W){1'b0}}};
                    div_next   = {{(RATE_W-SUM_W){1'b0}}, sum_reg + 5'd1};
                    cnt_next   = TRIAL_STEPS;
                    state_next = ST_TRIAL;
                end
            end
            ST_TRIAL:
            begin
                if (cnt_reg != '0)
                begin
                    rem_next = step_rem;
                    quo_next = step_quo;
                    cnt_next = cnt_reg - 5'd1;
                end
                else if (rem_reg == '0)
                begin
                    state_next = ST_CHECK;
                end
                else if (sum_reg == MIN_SUM)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    sum_next = sum_reg - 5'd1;
                    rem_next = '0;
                    quo_next = {quot_reg, {(CLK_W-QUOT_W){1'b0}}};
                    div_next = {{(RATE_W-SUM_W){1'b0}}, sum_reg};
                    cnt_next = TRIAL_STEPS;
                end
            end
            ST_CHECK:
            begin
                if (sol_ok)
                begin
                    res_ok_next    = 1'b1;
                    res_presc_next = presc_cand[PRESC_W-1:0];
                    res_seg1_next  = 4'(seg1_val - 5'd1);
                    res_seg2_next  = 3'(seg2_val - 5'd1);
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            clock_reg     <= CLOCK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                clock_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        div_reg       <= div_next;
        sum_reg       <= sum_next;
        quot_reg      <= quot_next;
        rem1_reg      <= rem1_next;
        res_ok_reg    <= res_ok_next;
        res_presc_reg <= res_presc_next;
        res_seg1_reg  <= res_seg1_next;
        res_seg2_reg  <= res_seg2_next;
        if (out_load)
        begin
            ok_reg    <= res_ok_reg;
            presc_reg <= res_presc_reg;
            sjw_reg   <= res_ok_reg ? SJW_CODE : 2'd0;
            seg1_reg  <= res_seg1_reg;
            seg2_reg  <= res_seg2_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ok              = ok_reg;
    assign prescaler       = presc_reg;
    assign jump_width_code = sjw_reg;
    assign seg1_code       = seg1_reg;
    assign seg2_code       = seg2_reg;

`ifndef SYNTHESIS
    // A successful result always carries the fixed jump width.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok |-> jump_width_code == SJW_CODE)
        else $error("successful result without fixed jump width");

    // A failed result carries zeros in every field.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> prescaler == '0 && jump_width_code == 2'd0
                             && seg1_code == 4'd0 && seg2_code == 3'd0)
        else $error("failed result with nonzero fields");

    // The step counter only runs while the divider is in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0 |-> state_reg == ST_DIV || state_reg == ST_TRIAL)
        else $error("step counter running outside divider states");

    // An accepted transaction always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != ST_IDLE)
        else $error("accepted transaction did not start work");
`endif

endmodule
`default_nettype wire

/* test/tb_can_bit_timing_solver_core.sv */
// ----------------------------------------------------------------------------
// CAN bit-timing solver testbench
// Sends bitrate requests through the valid/ready input channel under a series
// of peripheral clock settings and checks every timing result, field by field,
// against a behavioral solver or, for some directed rows, fixed values. It
// starts with a directed table, followed by mostly constructed requests aimed
// at exact divisors, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_can_bit_timing_solver_core;
    import cbts_pkg::*;

    localparam int NUM_PHASES   = 14;
    localparam int PHASE_ITEMS  = 120;
    localparam int NUM_DIRECTED = 23;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int REPORT_MAX   = 10;
    localparam int SAMPLE_LIMIT = 900;
    localparam logic [RATE_W-1:0] RATE_ALL_ONES = 20'hFFFFF;

    typedef struct packed {
        logic               ok;
        logic [PRESC_W-1:0] prescaler;
        logic [1:0]         jump_width;
        logic [3:0]         seg1;
        logic [2:0]         seg2;
    } timing_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic              from_table;
        timing_t           want;
    } row_t;

    localparam logic    FROM_TABLE = 1'b1;
    localparam logic    FROM_MODEL = 1'b0;
    localparam timing_t NO_FIT     = '0;
    localparam timing_t FIT_1M     = {1'b1, 11'd6, SJW_CODE, 4'd6, 3'd0};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CLK_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [RATE_W-1:0]  req_bitrate = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               ok;
    logic [PRESC_W-1:0] prescaler;
    logic [1:0]         jump_width_code;
    logic [3:0]         seg1_code;
    logic [2:0]         seg2_code;

    timing_t           awaited_timing[$];
    row_t              directed_rows [0:NUM_DIRECTED-1];
    logic [RATE_W-1:0] bus_rates [0:8];
    logic [CLK_W-1:0]  clock_plan [0:NUM_PHASES-1];
    logic [CLK_W-1:0]  model_clock = CLOCK_RESET;
    int                errors = 0;
    int                results_seen = 0;
    int                fits_seen = 0;
    int                cycles = 0;
    bit                gaps_on = 1'b1;
    bit                hold_request = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    can_bit_timing_solver_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_bitrate     (req_bitrate),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ok              (ok),
        .prescaler       (prescaler),
        .jump_width_code (jump_width_code),
        .seg1_code       (seg1_code),
        .seg2_code       (seg2_code)
    );

    function automatic timing_t solve_timing(input logic [CLK_W-1:0] clock_hz,
                                             input logic [RATE_W-1:0] rate);
        timing_t     fit;
        int unsigned quot;
        int unsigned presc;
        int unsigned seg1;
        int unsigned seg2;
        int          sum;
        fit = NO_FIT;
        if (rate == 0)
        begin
            return fit;
        end
        sum = (rate >= FAST_RATE) ? QUANTA_FAST - 1 : QUANTA_SLOW - 1;
        quot = clock_hz / rate;
        while (sum >= MIN_SUM && quot % (sum + 1) != 0)
        begin
            sum--;
        end
        if (sum < MIN_SUM)
        begin
            return fit;
        end
        presc = quot / (sum + 1);
        if (presc < 1 || presc > PRESCALER_MAX)
        begin
            return fit;
        end
        seg1 = (7 * sum + 3) / 8;
        if (PERMILL_FULL * (1 + seg1) / (1 + sum) > SAMPLE_LIMIT)
        begin
            seg1 = (7 * sum - 1) / 8;
        end
        if (seg1 > sum)
        begin
            return fit;
        end
        seg2 = sum - seg1;
        if (rate != clock_hz / (presc * (sum + 1)))
        begin
            return fit;
        end
        if (seg1 < 1 || seg1 > MAX_SEG1 || seg2 < 1 || seg2 > MAX_SEG2)
        begin
            return fit;
        end
        fit.ok         = 1'b1;
        fit.prescaler  = presc[PRESC_W-1:0];
        fit.jump_width = SJW_CODE;
        fit.seg1       = 4'(seg1 - 1);
        fit.seg2       = 3'(seg2 - 1);
        return fit;
    endfunction

    function automatic string describe(input timing_t t);
        return $sformatf("ok=%0d prescaler=%0d sjw=%0d seg1=%0d seg2=%0d",
                         t.ok, t.prescaler, t.jump_width, t.seg1, t.seg2);
    endfunction

    task automatic report_failure(input string what);
        errors++;
        if (errors <= REPORT_MAX)
        begin
            $display("ERROR: %s", what);
        end
    endtask

    task automatic offer_rate(input logic [RATE_W-1:0] rate, input logic from_table,
                              input timing_t want);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_bitrate <= rate;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        awaited_timing.push_back(from_table ? want : solve_timing(model_clock, rate));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (awaited_timing.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin : check_results
        timing_t got;
        timing_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {ok, prescaler, jump_width_code, seg1_code, seg2_code};
            results_seen++;
            if (got.ok === 1'b1)
            begin
                fits_seen++;
            end
            if (awaited_timing.size() == 0)
            begin
                report_failure($sformatf("unexpected result: %s", describe(got)));
            end
            else
            begin
                want = awaited_timing.pop_front();
                if (got.ok !== want.ok || got.prescaler !== want.prescaler
                    || got.jump_width !== want.jump_width || got.seg1 !== want.seg1
                    || got.seg2 !== want.seg2)
                begin
                    report_failure($sformatf("result %0d at clock %0d: expected %s, got %s",
                                             results_seen, model_clock, describe(want),
                                             describe(got)));
                end
            end
        end
    end

    initial
    begin : receiver
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 18);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int                p;
        int                k;
        int unsigned       pick_presc;
        int unsigned       pick_sum;
        int unsigned       pick_quot;
        logic [RATE_W-1:0] rate;

        directed_rows = '{
            {20'd1000000, FROM_TABLE, FIT_1M},
            {20'd0,       FROM_TABLE, NO_FIT},
            {20'd1,       FROM_TABLE, NO_FIT},
            {RATE_ALL_ONES, FROM_TABLE, NO_FIT},
            {20'd500000,  FROM_MODEL, NO_FIT},
            {20'd250000,  FROM_MODEL, NO_FIT},
            {20'd125000,  FROM_MODEL, NO_FIT},
            {20'd100000,  FROM_MODEL, NO_FIT},
            {20'd50000,   FROM_MODEL, NO_FIT},
            {20'd20000,   FROM_MODEL, NO_FIT},
            {20'd10000,   FROM_MODEL, NO_FIT},
            {20'd999999,  FROM_MODEL, NO_FIT},
            {20'd1000001, FROM_MODEL, NO_FIT},
            {20'd800000,  FROM_MODEL, NO_FIT},
            {20'd915254,  FROM_MODEL, NO_FIT},
            {20'd2929,    FROM_MODEL, NO_FIT},
            {20'd3000,    FROM_MODEL, NO_FIT},
            {20'd3125,    FROM_MODEL, NO_FIT},
            {20'd216000,  FROM_MODEL, NO_FIT},
            {20'd540000,  FROM_MODEL, NO_FIT},
            {20'd900000,  FROM_MODEL, NO_FIT},
            {20'h55555,   FROM_MODEL, NO_FIT},
            {20'hAAAAA,   FROM_MODEL, NO_FIT}
        };
        bus_rates = '{20'd10000, 20'd20000, 20'd50000, 20'd83333, 20'd100000,
                      20'd125000, 20'd250000, 20'd500000, 20'd1000000};
        clock_plan = '{28'd54000000, 28'd216000000, 28'd0, 28'd1, 28'hFFFFFFF,
                       28'd8000000, 28'd16000000, 28'd36000000, 28'd42000000,
                       28'd48000000, 28'd73728000, 28'd80000000, 28'd0, 28'd0};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < NUM_DIRECTED; k++)
        begin
            offer_rate(directed_rows[k].rate, directed_rows[k].from_table,
                       directed_rows[k].want);
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            if (p >= NUM_PHASES - 2)
            begin
                clock_plan[p] = CLK_W'($urandom_range(1, 216000000));
            end
            cfg_valid <= 1'b1;
            cfg_data <= clock_plan[p];
            do
            begin
                @(posedge clk);
            end
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            model_clock = clock_plan[p];
            gaps_on = (p % 5 != 2) && (p != NUM_PHASES - 1);
            if (p == 0)
            begin
                hold_request = 1'b1;
            end
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        pick_presc = ($urandom_range(0, 3) == 0)
                                     ? $urandom_range(1, PRESCALER_MAX) : $urandom_range(1, 40);
                        pick_sum = $urandom_range(MIN_SUM, QUANTA_SLOW - 1);
                        pick_quot = model_clock / (pick_presc * (pick_sum + 1));
                        if (pick_quot > RATE_ALL_ONES)
                        begin
                            rate = RATE_W'($urandom_range(1, RATE_ALL_ONES));
                        end
                        else
                        begin
                            rate = pick_quot[RATE_W-1:0];
                        end
                    end
                    6, 7:
                    begin
                        rate = bus_rates[$urandom_range(0, 8)];
                    end
                    8:
                    begin
                        rate = RATE_W'($urandom_range(0, RATE_ALL_ONES));
                    end
                    default:
                    begin
                        rate = RATE_W'(($urandom_range(0, 1) == 1)
                               ? $urandom_range(999990, 1000010) : $urandom_range(0, 3));
                    end
                endcase
                offer_rate(rate, FROM_MODEL, NO_FIT);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d bitrate requests across %0d clock settings.",
                 results_seen, NUM_PHASES + 1);
        $display("%0d requests yielded a timing solution; %0d failures were counted.",
                 fits_seen, errors);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
